@@ design/lsbp_pkg.sv @@
`timescale 1ns / 1ps

package lsbp_pkg;

  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_HUFF  = 2'd1;
  localparam logic [1:0] OP_ALIGN = 2'd2;

  localparam int OP_W     = 2;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 32;
  localparam int PEND_W   = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic load;    // capture the accepted item into the accumulator
    logic shift;   // drop the byte just delivered
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_byte;  // at least one complete byte in the accumulator
    logic last;      // the current byte is the final one of this item
  } dp_status_t;

endpackage

@@ design/lsbp_in_if.sv @@
`timescale 1ns / 1ps

interface lsbp_in_if;
  import lsbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output op, output code, output length, input ready);
  modport sink   (input valid, input op, input code, input length, output ready);
endinterface

@@ design/lsbp_out_if.sv @@
`timescale 1ns / 1ps

interface lsbp_out_if;
  import lsbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] byte_count;
  logic               last;

  modport source (output valid, output out_byte, output byte_count, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_count, input last, output ready);
endinterface

@@ design/lsb_first_bit_packer.sv @@
`timescale 1ns / 1ps

// LSB-first bit packer for Deflate-style streams.
// item channel (sink): op, code, length. op raw appends the low length bits
// of code, op huff appends them in reversed order, op align pads out any
// partial byte. length is clamped to MAX_CODE_BITS; op 3 is dropped.
// result channel (source): out_byte (earliest bit in bit 0), byte_count
// (running total including this byte, saturating at all ones), last (set on
// the final byte produced by an item).
// Timing: an item is taken when the block is idle; its bytes follow
// starting the next cycle, one per cycle while the receiver is ready.
// Bytes leave through the single byte output port driven straight from
// the shift accumulator.
// When the receiver stalls, the current byte holds and no new item is taken
// until every byte of the present item has been delivered.
// Reset (rst, synchronous) clears the pending bits and the byte count.

module lsb_first_bit_packer
  import lsbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  lsbp_in_if.sink     item,
  lsbp_out_if.source  result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lsbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsbp_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (item.op),
    .code       (item.code),
    .length     (item.length),
    .status     (status),
    .out_byte   (result.out_byte),
    .byte_count (result.byte_count)
  );

  assign result.last = status.last;

endmodule

@@ design/lsbp_ctrl.sv @@
`timescale 1ns / 1ps

module lsbp_ctrl
  import lsbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = status.has_byte;
        if (!status.has_byte) begin
          state_next = S_IDLE;
        end else if (out_ready) begin
          cmd.shift = 1'b1;
          if (status.last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ design/lsbp_datapath.sv @@
`timescale 1ns / 1ps

module lsbp_datapath
  import lsbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  input  logic [OP_W-1:0]    op,
  input  logic [CODE_W-1:0]  code,
  input  logic [LEN_W-1:0]   length,
  output dp_status_t         status,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [COUNT_W-1:0] byte_count
);

  localparam int ACC_W  = PEND_W + MAX_CODE_BITS;
  localparam int FILL_W = $clog2(ACC_W + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_BITS);

  logic [ACC_W-1:0]         acc;
  logic [FILL_W-1:0]        fill;
  logic [COUNT_W-1:0]       cnt;
  logic [ACC_W-1:0]         acc_next;
  logic [FILL_W-1:0]        fill_next;
  logic [COUNT_W-1:0]       cnt_next;

  logic [LEN_W-1:0]         len_c;
  logic [MAX_CODE_BITS-1:0] mask;
  logic [MAX_CODE_BITS-1:0] bits_raw;
  logic [MAX_CODE_BITS-1:0] bits_rev;
  logic [MAX_CODE_BITS-1:0] bits;

  assign len_c    = (length > LEN_MAX) ? LEN_MAX : length;
  assign mask     = ~({MAX_CODE_BITS{1'b1}} << len_c);
  assign bits_raw = code[MAX_CODE_BITS-1:0] & mask;

  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      bits_rev[i] = bits_raw[MAX_CODE_BITS-1-i];
    end
  end

  // reversed word sits at the top; slide it down so it spans len_c bits
  assign bits = (op == OP_HUFF) ? (bits_rev >> (LEN_MAX - len_c)) : bits_raw;

  assign status.has_byte = |fill[FILL_W-1:3];
  assign status.last     = (fill[FILL_W-1:3] == (FILL_W-3)'(1));
  assign out_byte        = acc[BYTE_W-1:0];
  assign cnt_next        = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
  assign byte_count      = cnt_next;

  always_comb begin
    acc_next  = acc;
    fill_next = fill;
    if (cmd.load) begin
      case (op)
        OP_RAW, OP_HUFF: begin
          // bits above fill are always zero, so OR places the new code
          acc_next  = acc | (ACC_W'(bits) << fill[2:0]);
          fill_next = fill + FILL_W'(len_c);
        end
        OP_ALIGN: begin
          // a partial byte goes out as one full byte with zero padding
          fill_next = (fill != '0) ? FILL_W'(BYTE_W) : '0;
        end
        default: ;
      endcase
    end else if (cmd.shift) begin
      acc_next  = acc >> BYTE_W;
      fill_next = fill - FILL_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      fill <= '0;
      cnt  <= '0;
    end else begin
      acc  <= acc_next;
      fill <= fill_next;
      if (cmd.shift) cnt <= cnt_next;
    end
  end

endmodule
